>>> rtl/iqts_pkg.sv
// ----------------------------------------------------------------------------
// iqts_pkg
// Shared types and codes of the idempotent query transaction server.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iqts_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_GET     = 2'd1,
    REQ_UNKNOWN = 2'd2,
    REQ_POLL    = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_ACCEPTED    = 4'd0,
    ST_IN_PROGRESS = 4'd1,
    ST_COMPLETE    = 4'd2,
    ST_BUSY        = 4'd3,
    ST_NOT_SAFE    = 4'd4,
    ST_INVALID     = 4'd5,
    ST_NOT_FOUND   = 4'd6,
    ST_BAD_VERSION = 4'd7,
    ST_INTERNAL    = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_REPLY_VERSION    = 2'd1,
    CFG_CONFIRM_VALUE    = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_idx_t;

  // One transaction slot: owner node, request id, motor mask
  typedef struct packed {
    logic [6:0]  node;
    logic [15:0] req;
    logic [7:0]  mask;
  } slot_t;

  // One request beat as held in the input register
  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  source_node;
    logic [15:0] txn_id;
    logic [7:0]  motor_sel;
    logic [15:0] confirmation;
    logic [7:0]  version;
    logic        query_busy;
    logic        command_busy;
    logic        start_ok;
    logic        result_present;
    logic [47:0] result_masks;
    logic [7:0]  maint_code;
  } req_t;

  // One response beat as held in the result register
  typedef struct packed {
    status_t     status;
    logic [7:0]  resp_version;
    logic [15:0] echo_txn_id;
    slot_t       owner;
    logic [47:0] out_masks;
    logic [7:0]  out_maint;
    logic        start_issue;
  } rsp_t;

  // Transaction state seen by the decision logic
  typedef struct packed {
    logic        act_valid;
    slot_t       act;
    logic        done_valid;
    slot_t       done;
    logic        cache_valid;
    logic [47:0] cache_masks;
    logic [7:0]  cache_maint;
  } state_t;

  // Slot update commands from the decision logic
  typedef struct packed {
    logic start;    // load the active slot from the request
    logic retire;   // move active to completed, refill the cache
    logic present;  // cache takes the lower result on retire
  } upd_t;

  // Configuration register values
  typedef struct packed {
    logic [7:0]  expected_version;
    logic [7:0]  reply_version;
    logic [15:0] confirm_value;
  } cfg_t;

endpackage

>>> rtl/iqts_req_if.sv
// ----------------------------------------------------------------------------
// iqts_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iqts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  source_node;
  logic [15:0] txn_id;
  logic [7:0]  motor_sel;
  logic [15:0] confirmation;
  logic [7:0]  version;
  logic        query_busy;
  logic        command_busy;
  logic        start_ok;
  logic        result_present;
  logic [47:0] result_masks;
  logic [7:0]  maint_code;

  modport source (
    output valid, req_type, source_node, txn_id, motor_sel, confirmation,
           version, query_busy, command_busy, start_ok, result_present,
           result_masks, maint_code,
    input  ready
  );

  modport sink (
    input  valid, req_type, source_node, txn_id, motor_sel, confirmation,
           version, query_busy, command_busy, start_ok, result_present,
           result_masks, maint_code,
    output ready
  );
endinterface

>>> rtl/iqts_rsp_if.sv
// ----------------------------------------------------------------------------
// iqts_rsp_if
// Response channel: valid/ready handshake with the response fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iqts_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  resp_version;
  logic [15:0] echo_txn_id;
  logic [6:0]  owner_node;
  logic [15:0] owner_txn_id;
  logic [7:0]  owner_mask;
  logic [47:0] out_masks;
  logic [7:0]  out_maint;
  logic        start_issue;

  modport source (
    output valid, status, resp_version, echo_txn_id, owner_node,
           owner_txn_id, owner_mask, out_masks, out_maint, start_issue,
    input  ready
  );

  modport sink (
    input  valid, status, resp_version, echo_txn_id, owner_node,
           owner_txn_id, owner_mask, out_masks, out_maint, start_issue,
    output ready
  );
endinterface

>>> rtl/iqts_cfg_if.sv
// ----------------------------------------------------------------------------
// iqts_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iqts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/iqts_decide.sv
// ----------------------------------------------------------------------------
// iqts_decide
// Combinational decision logic: classifies one request against the slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iqts_decide (
  input  iqts_pkg::req_t   req,
  input  iqts_pkg::state_t st,
  input  iqts_pkg::cfg_t   cfg,
  output iqts_pkg::rsp_t   rsp,
  output logic             has_rsp,
  output iqts_pkg::upd_t   upd
);

  logic               match_act;
  logic               match_done;
  iqts_pkg::status_t  cached_status;
  logic [47:0]        cached_masks;
  logic [7:0]         cached_maint;
  iqts_pkg::slot_t    req_slot;

  assign req_slot.node = req.source_node;
  assign req_slot.req  = req.txn_id;
  assign req_slot.mask = req.motor_sel;

  assign match_act  = st.act_valid && (st.act.node == req.source_node) &&
                      (st.act.req == req.txn_id);
  assign match_done = st.done_valid && (st.done.node == req.source_node) &&
                      (st.done.req == req.txn_id);

  // Report the cached result of the completed slot
  always_comb begin
    if (!st.cache_valid) begin
      cached_status = iqts_pkg::ST_INTERNAL;
      cached_masks  = '0;
      cached_maint  = '0;
    end else begin
      cached_status = (st.cache_maint == 8'd0) ? iqts_pkg::ST_COMPLETE
                                               : iqts_pkg::ST_INTERNAL;
      cached_masks  = st.cache_masks;
      cached_maint  = st.cache_maint;
    end
  end

  assign has_rsp = (req.req_type != iqts_pkg::REQ_POLL);

  always_comb begin
    rsp                 = '0;
    upd                 = '0;
    rsp.status          = iqts_pkg::ST_ACCEPTED;
    rsp.resp_version    = cfg.reply_version;
    rsp.echo_txn_id     = req.txn_id;
    if (st.act_valid) begin
      rsp.owner = st.act;
    end else if (st.done_valid) begin
      rsp.owner = st.done;
    end

    if (req.req_type == iqts_pkg::REQ_POLL) begin
      upd.retire  = st.act_valid && !req.query_busy;
      upd.present = req.result_present;
    end else if (req.version != cfg.expected_version) begin
      rsp.status = iqts_pkg::ST_BAD_VERSION;
    end else if (req.req_type == iqts_pkg::REQ_START) begin
      if (req.motor_sel == 8'd0 || req.confirmation != cfg.confirm_value) begin
        rsp.status = iqts_pkg::ST_INVALID;
      end else if (match_act) begin
        rsp.owner  = st.act;
        rsp.status = (st.act.mask == req.motor_sel) ? iqts_pkg::ST_IN_PROGRESS
                                                    : iqts_pkg::ST_INVALID;
      end else if (match_done) begin
        rsp.owner = st.done;
        if (st.done.mask != req.motor_sel) begin
          rsp.status = iqts_pkg::ST_INVALID;
        end else begin
          rsp.status    = cached_status;
          rsp.out_masks = cached_masks;
          rsp.out_maint = cached_maint;
        end
      end else if (st.act_valid || req.query_busy) begin
        rsp.status = iqts_pkg::ST_BUSY;
      end else if (req.command_busy || !req.start_ok) begin
        rsp.status = iqts_pkg::ST_NOT_SAFE;
      end else begin
        upd.start       = 1'b1;
        rsp.owner       = req_slot;
        rsp.start_issue = 1'b1;
        rsp.status      = iqts_pkg::ST_ACCEPTED;
      end
    end else if (req.req_type == iqts_pkg::REQ_GET) begin
      if (match_act) begin
        rsp.owner  = st.act;
        rsp.status = iqts_pkg::ST_IN_PROGRESS;
      end else if (match_done) begin
        rsp.owner     = st.done;
        rsp.status    = cached_status;
        rsp.out_masks = cached_masks;
        rsp.out_maint = cached_maint;
      end else begin
        rsp.status = iqts_pkg::ST_NOT_FOUND;
      end
    end else begin
      rsp.status = iqts_pkg::ST_INVALID;
    end
  end

endmodule

>>> rtl/iqts_slots.sv
// ----------------------------------------------------------------------------
// iqts_slots
// Active slot, completed slot and cached final result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iqts_slots (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  iqts_pkg::upd_t   upd,
  input  iqts_pkg::slot_t  new_slot,
  input  logic [47:0]      new_masks,
  input  logic [7:0]       new_maint,
  output iqts_pkg::state_t st
);

  logic            act_valid_r;
  iqts_pkg::slot_t act_r;
  logic            done_valid_r;
  iqts_pkg::slot_t done_r;
  logic            cache_valid_r;
  logic [47:0]     cache_masks_r;
  logic [7:0]      cache_maint_r;

  // Valid flags gate every read of the slot payload, so only they reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r   <= 1'b0;
      done_valid_r  <= 1'b0;
      cache_valid_r <= 1'b0;
    end else if (fire) begin
      if (upd.start) begin
        act_valid_r <= 1'b1;
      end else if (upd.retire) begin
        act_valid_r   <= 1'b0;
        done_valid_r  <= 1'b1;
        cache_valid_r <= upd.present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && upd.start) begin
      act_r <= new_slot;
    end
    if (fire && upd.retire) begin
      done_r        <= act_r;
      cache_masks_r <= upd.present ? new_masks : 48'd0;
      cache_maint_r <= upd.present ? new_maint : 8'd0;
    end
  end

  assign st.act_valid   = act_valid_r;
  assign st.act         = act_r;
  assign st.done_valid  = done_valid_r;
  assign st.done        = done_r;
  assign st.cache_valid = cache_valid_r;
  assign st.cache_masks = cache_masks_r;
  assign st.cache_maint = cache_maint_r;

endmodule

>>> rtl/idempotent_query_transaction_server.sv
// ----------------------------------------------------------------------------
// idempotent_query_transaction_server
// Server side of an idempotent start/get-result query service. Each request
// beat is captured in an input register, decided combinationally against the
// active slot, the completed slot and the cached result, and its response is
// written to a result register. One request beat is accepted every cycle while
// the result register is not stalled. A poll tick passes through the input
// register, may retire the active slot into the completed slot with the
// lower engine's result, and yields no response beat. The input register
// moves on while the result register is free or being taken, so a stalled
// response holds at most one request behind it. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idempotent_query_transaction_server (
  input  logic        clk,
  input  logic        rst_n,
  iqts_req_if.sink    in_ch,
  iqts_rsp_if.source  out_ch,
  iqts_cfg_if.sink    cfg_ch
);

  // Configuration registers
  iqts_pkg::cfg_t   cfg_r;

  // Input register stage
  logic             s1_valid_r;
  iqts_pkg::req_t   s1_req_r;
  logic             s1_go;
  logic             in_fire;

  // Decision results
  iqts_pkg::rsp_t   rsp;
  logic             has_rsp;
  iqts_pkg::upd_t   upd;
  iqts_pkg::state_t st;

  // Result register stage
  logic             out_valid_r;
  logic             out_valid_nxt;
  iqts_pkg::rsp_t   out_r;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, drop writes beyond the register list
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (iqts_pkg::cfg_idx_t'(cfg_ch.index))
        iqts_pkg::CFG_EXPECTED_VERSION: cfg_r.expected_version <= cfg_ch.data[7:0];
        iqts_pkg::CFG_REPLY_VERSION:    cfg_r.reply_version    <= cfg_ch.data[7:0];
        iqts_pkg::CFG_CONFIRM_VALUE:    cfg_r.confirm_value    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register: advance when the beat is a poll or the result register
  // frees up this cycle
  // --------------------------------------------------------------------------
  assign s1_go       = s1_valid_r && (!has_rsp || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.req_type       <= in_ch.req_type;
      s1_req_r.source_node    <= in_ch.source_node;
      s1_req_r.txn_id         <= in_ch.txn_id;
      s1_req_r.motor_sel      <= in_ch.motor_sel;
      s1_req_r.confirmation   <= in_ch.confirmation;
      s1_req_r.version        <= in_ch.version;
      s1_req_r.query_busy     <= in_ch.query_busy;
      s1_req_r.command_busy   <= in_ch.command_busy;
      s1_req_r.start_ok       <= in_ch.start_ok;
      s1_req_r.result_present <= in_ch.result_present;
      s1_req_r.result_masks   <= in_ch.result_masks;
      s1_req_r.maint_code     <= in_ch.maint_code;
    end
  end

  // --------------------------------------------------------------------------
  // Decision and slot state: the slots update on the edge the beat leaves
  // the input register, so the next beat sees them
  // --------------------------------------------------------------------------
  iqts_decide u_decide (
    .req     (s1_req_r),
    .st      (st),
    .cfg     (cfg_r),
    .rsp     (rsp),
    .has_rsp (has_rsp),
    .upd     (upd)
  );

  iqts_slots u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .upd       (upd),
    .new_slot  (rsp.owner),
    .new_masks (s1_req_r.result_masks),
    .new_maint (s1_req_r.maint_code),
    .st        (st)
  );

  // --------------------------------------------------------------------------
  // Result register: hold while stalled, load a response beat on advance
  // --------------------------------------------------------------------------
  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || (s1_go && has_rsp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_rsp) begin
      out_r <= rsp;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.resp_version = out_r.resp_version;
  assign out_ch.echo_txn_id  = out_r.echo_txn_id;
  assign out_ch.owner_node   = out_r.owner.node;
  assign out_ch.owner_txn_id = out_r.owner.req;
  assign out_ch.owner_mask   = out_r.owner.mask;
  assign out_ch.out_masks    = out_r.out_masks;
  assign out_ch.out_maint    = out_r.out_maint;
  assign out_ch.start_issue  = out_r.start_issue;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An issued start is reported as accepted
  a_issue_accepted : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.start_issue |-> out_r.status == iqts_pkg::ST_ACCEPTED)
    else $error("start issued without accepted status");

  // An accepted start leaves the active slot occupied
  a_start_loads_act : assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && upd.start |=> st.act_valid)
    else $error("active slot not loaded after start");

  // A complete status carries a zero maintenance code
  a_complete_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == iqts_pkg::ST_COMPLETE |-> out_r.out_maint == 8'd0)
    else $error("complete status with maintenance code");

  // A poll tick never produces a response beat
  a_poll_silent : assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !has_rsp && (!out_valid_r || out_ch.ready) |=> !out_valid_r)
    else $error("poll tick produced a response");

  // A retire empties the active slot and fills the completed slot
  a_retire_moves : assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && upd.retire |=> !st.act_valid && st.done_valid)
    else $error("retire did not move the active slot");

endmodule

>>> sim/iqts_reply_checker.sv
// ----------------------------------------------------------------------------
// iqts_reply_checker
// Watches the request, response and configuration channels of the query
// transaction server. Keeps its own copy of the slots, the cached result and
// the registers, works out the reply of each accepted request and compares
// every response beat, field by field, with the oldest reply still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iqts_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  iqts_req_if         req_mon,
  iqts_rsp_if         rsp_mon,
  iqts_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned replies_pending
);

  iqts_pkg::cfg_t   regs;
  iqts_pkg::state_t txn;
  iqts_pkg::rsp_t   replies_due[$];

  task automatic report(input string line);
    if (mismatches < 200) $display("%0t ns: %s", $time, line);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] want);
    if (seen !== want)
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, seen, want));
  endtask

  // Report the cached lower result, or an internal error without one
  task automatic give_cached(inout iqts_pkg::rsp_t a);
    if (!txn.cache_valid) begin
      a.status = iqts_pkg::ST_INTERNAL;
    end else begin
      a.out_masks = txn.cache_masks;
      a.out_maint = txn.cache_maint;
      a.status    = (txn.cache_maint == 8'd0) ? iqts_pkg::ST_COMPLETE
                                              : iqts_pkg::ST_INTERNAL;
    end
  endtask

  task automatic decide_reply(input iqts_pkg::req_t q, output bit answers,
                              output iqts_pkg::rsp_t a);
    bit on_act;
    bit on_done;
    a       = '0;
    answers = (q.req_type != iqts_pkg::REQ_POLL);
    on_act  = txn.act_valid && txn.act.node == q.source_node &&
              txn.act.req == q.txn_id;
    on_done = txn.done_valid && txn.done.node == q.source_node &&
              txn.done.req == q.txn_id;
    if (!answers) begin
      // Poll tick: retire a finished active slot, refill the cache
      if (txn.act_valid && !q.query_busy) begin
        txn.done_valid  = 1'b1;
        txn.done        = txn.act;
        txn.cache_valid = q.result_present;
        txn.cache_masks = q.result_present ? q.result_masks : 48'd0;
        txn.cache_maint = q.result_present ? q.maint_code : 8'd0;
        txn.act_valid   = 1'b0;
        txn.act         = '0;
      end
    end else begin
      a.resp_version = regs.reply_version;
      a.echo_txn_id  = q.txn_id;
      if (txn.act_valid) a.owner = txn.act;
      else if (txn.done_valid) a.owner = txn.done;
      if (q.version != regs.expected_version) begin
        a.status = iqts_pkg::ST_BAD_VERSION;
      end else if (q.req_type == iqts_pkg::REQ_START) begin
        if (q.motor_sel == 8'd0 || q.confirmation != regs.confirm_value) begin
          a.status = iqts_pkg::ST_INVALID;
        end else if (on_act) begin
          a.owner  = txn.act;
          a.status = (txn.act.mask == q.motor_sel) ? iqts_pkg::ST_IN_PROGRESS
                                                   : iqts_pkg::ST_INVALID;
        end else if (on_done) begin
          a.owner = txn.done;
          if (txn.done.mask != q.motor_sel) a.status = iqts_pkg::ST_INVALID;
          else give_cached(a);
        end else if (txn.act_valid || q.query_busy) begin
          a.status = iqts_pkg::ST_BUSY;
        end else if (q.command_busy || !q.start_ok) begin
          a.status = iqts_pkg::ST_NOT_SAFE;
        end else begin
          txn.act_valid = 1'b1;
          txn.act.node  = q.source_node;
          txn.act.req   = q.txn_id;
          txn.act.mask  = q.motor_sel;
          a.owner       = txn.act;
          a.start_issue = 1'b1;
          a.status      = iqts_pkg::ST_ACCEPTED;
        end
      end else if (q.req_type == iqts_pkg::REQ_GET) begin
        if (on_act) begin
          a.owner  = txn.act;
          a.status = iqts_pkg::ST_IN_PROGRESS;
        end else if (on_done) begin
          a.owner = txn.done;
          give_cached(a);
        end else begin
          a.status = iqts_pkg::ST_NOT_FOUND;
        end
      end else begin
        a.status = iqts_pkg::ST_INVALID;
      end
    end
  endtask

  always @(posedge clk) begin
    iqts_pkg::req_t beat;
    iqts_pkg::rsp_t want;
    bit             answers;
    if (!rst_n) begin
      regs = '0;
      txn  = '0;
      replies_due.delete();
      mismatches = 0;
      replies_pending <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (iqts_pkg::cfg_idx_t'(cfg_mon.index))
          iqts_pkg::CFG_EXPECTED_VERSION: regs.expected_version = cfg_mon.data[7:0];
          iqts_pkg::CFG_REPLY_VERSION:    regs.reply_version    = cfg_mon.data[7:0];
          iqts_pkg::CFG_CONFIRM_VALUE:    regs.confirm_value    = cfg_mon.data;
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (replies_due.size() == 0) begin
          report($sformatf("response beat with no reply due, status 0x%0h",
                           rsp_mon.status));
        end else begin
          want = replies_due.pop_front();
          check_field("status", 64'(rsp_mon.status), 64'(want.status));
          check_field("resp_version", 64'(rsp_mon.resp_version),
                      64'(want.resp_version));
          check_field("echo_txn_id", 64'(rsp_mon.echo_txn_id),
                      64'(want.echo_txn_id));
          check_field("owner_node", 64'(rsp_mon.owner_node), 64'(want.owner.node));
          check_field("owner_txn_id", 64'(rsp_mon.owner_txn_id),
                      64'(want.owner.req));
          check_field("owner_mask", 64'(rsp_mon.owner_mask), 64'(want.owner.mask));
          check_field("out_masks", 64'(rsp_mon.out_masks), 64'(want.out_masks));
          check_field("out_maint", 64'(rsp_mon.out_maint), 64'(want.out_maint));
          check_field("start_issue", 64'(rsp_mon.start_issue),
                      64'(want.start_issue));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        beat = {req_mon.req_type, req_mon.source_node, req_mon.txn_id,
                req_mon.motor_sel, req_mon.confirmation, req_mon.version,
                req_mon.query_busy, req_mon.command_busy, req_mon.start_ok,
                req_mon.result_present, req_mon.result_masks, req_mon.maint_code};
        decide_reply(beat, answers, want);
        if (answers) replies_due.push_back(want);
      end
      replies_pending <= replies_due.size();
    end
  end

endmodule

>>> sim/tb_idempotent_query_transaction_server.sv
// ----------------------------------------------------------------------------
// tb_idempotent_query_transaction_server
// Drives the query transaction server through a directed opening and three
// register settings of random request traffic, with random gaps on both
// channels, a gapless stretch and two long response stalls. The reply checker
// beside the block predicts and compares; this module only gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_idempotent_query_transaction_server;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned IDLE_PCT      = 11;
  localparam int unsigned HOLD_CYCLES   = 48;
  // Covers a trailing poll tick after the last reply is taken
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned replies_pending;
  int unsigned cycles;
  bit          no_gaps = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served;
  int unsigned hold_left;
  logic [7:0]  cur_ev;
  logic [15:0] cur_cv;

  // Small pool of transactions, so duplicates and result lookups hit often
  logic [6:0]  pool_node [4];
  logic [15:0] pool_id   [4];
  logic [7:0]  pool_mask [4];

  iqts_req_if req_bus ();
  iqts_rsp_if rsp_bus ();
  iqts_cfg_if cfg_bus ();

  idempotent_query_transaction_server uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus),
    .cfg_ch (cfg_bus)
  );

  iqts_reply_checker replies (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_mon         (req_bus),
    .rsp_mon         (rsp_bus),
    .cfg_mon         (cfg_bus),
    .mismatches      (mismatches),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a reply that never comes ends here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Response side: random stalls, none while gapless, and a long hold
  // whenever the stimulus asks for one
  initial begin
    rsp_bus.ready <= 1'b0;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request beat, with a random gap first; return at the edge
  // that takes it, leaving valid high
  task automatic send_beat(input iqts_pkg::req_t r);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    {req_bus.req_type, req_bus.source_node, req_bus.txn_id, req_bus.motor_sel,
     req_bus.confirmation, req_bus.version, req_bus.query_busy, req_bus.command_busy,
     req_bus.start_ok, req_bus.result_present, req_bus.result_masks,
     req_bus.maint_code} <= r;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Drop valid, wait out every reply due, then let a last poll tick finish
  task automatic settle();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; the caller drops it
  task automatic write_reg(input iqts_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Load all registers; junk in the upper byte of 8-bit registers must be
  // dropped, and a write to the unused index must change nothing
  task automatic program_regs(input logic [7:0] ev, input logic [7:0] rv,
                              input logic [15:0] cv, input bit poke_unused);
    logic [7:0]  pad;
    logic [15:0] junk;
    pad  = 8'($urandom);
    junk = 16'($urandom);
    write_reg(iqts_pkg::CFG_EXPECTED_VERSION, {pad, ev});
    write_reg(iqts_pkg::CFG_REPLY_VERSION, {~pad, rv});
    write_reg(iqts_pkg::CFG_CONFIRM_VALUE, cv);
    if (poke_unused) write_reg(iqts_pkg::CFG_UNUSED, junk);
    cfg_bus.valid <= 1'b0;
    cur_ev = ev;
    cur_cv = cv;
  endtask

  // Request that passes the version and confirmation checks
  function automatic iqts_pkg::req_t well_formed(input iqts_pkg::req_type_t t,
                                                 input logic [6:0] node,
                                                 input logic [15:0] id,
                                                 input logic [7:0] mask);
    iqts_pkg::req_t r;
    r              = '0;
    r.req_type     = t;
    r.source_node  = node;
    r.txn_id       = id;
    r.motor_sel    = mask;
    r.confirmation = cur_cv;
    r.version      = cur_ev;
    r.start_ok     = 1'b1;
    return r;
  endfunction

  // Mostly well-formed traffic on the pooled transactions; the rest is noise
  function automatic iqts_pkg::req_t random_beat();
    iqts_pkg::req_t      r;
    iqts_pkg::req_type_t t;
    logic [127:0]        noise;
    int unsigned         slot;
    int unsigned         kind;
    if ($urandom_range(99) < 10) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      r     = noise[$bits(iqts_pkg::req_t)-1:0];
      return r;
    end
    slot = $urandom_range(3);
    if ($urandom_range(99) < 8) begin
      pool_node[slot] = 7'($urandom);
      pool_id[slot]   = 16'($urandom);
      pool_mask[slot] = 8'($urandom);
    end
    kind = $urandom_range(99);
    if (kind < 40) t = iqts_pkg::REQ_START;
    else if (kind < 70) t = iqts_pkg::REQ_GET;
    else if (kind < 95) t = iqts_pkg::REQ_POLL;
    else t = iqts_pkg::REQ_UNKNOWN;
    r = well_formed(t, pool_node[slot], pool_id[slot], pool_mask[slot]);
    if ($urandom_range(99) < 12)
      r.motor_sel = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
    if ($urandom_range(99) < 5) r.confirmation = 16'($urandom);
    if ($urandom_range(99) < 4) r.version = 8'($urandom);
    r.query_busy     = $urandom_range(99) < 20;
    r.command_busy   = $urandom_range(99) < 10;
    r.start_ok       = $urandom_range(99) >= 10;
    r.result_present = $urandom_range(99) < 80;
    r.result_masks   = 48'({$urandom, $urandom});
    r.maint_code     = ($urandom_range(99) < 70) ? 8'd0 : 8'($urandom);
    return r;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned hold_at,
                            input int unsigned gapless);
    for (int unsigned n = 0; n < count; n++) begin
      no_gaps = (n < gapless);
      // Stall responses while requests keep coming, so the block backs up
      if (n == hold_at) hold_requests++;
      send_beat(random_beat());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    iqts_pkg::req_t r;
    rst_n                  <= 1'b0;
    req_bus.valid          <= 1'b0;
    req_bus.req_type       <= iqts_pkg::REQ_START;
    req_bus.source_node    <= '0;
    req_bus.txn_id         <= '0;
    req_bus.motor_sel      <= '0;
    req_bus.confirmation   <= '0;
    req_bus.version        <= '0;
    req_bus.query_busy     <= 1'b0;
    req_bus.command_busy   <= 1'b0;
    req_bus.start_ok       <= 1'b0;
    req_bus.result_present <= 1'b0;
    req_bus.result_masks   <= '0;
    req_bus.maint_code     <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= iqts_pkg::CFG_EXPECTED_VERSION;
    cfg_bus.data           <= '0;
    cur_ev = '0;
    cur_cv = '0;
    foreach (pool_node[i]) begin
      pool_node[i] = 7'($urandom);
      pool_id[i]   = 16'($urandom);
      pool_mask[i] = 8'($urandom_range(255, 1));
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Directed opening: every rejection, every status, both slot paths
    program_regs(8'h00, 8'hFF, 16'h0000, 1'b0);
    send_beat(well_formed(iqts_pkg::REQ_GET, 7'd5, 16'd1, 8'h01));       // nothing known
    r = well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h01);
    r.version = ~cur_ev;
    send_beat(r);                                                   // bad version
    r = well_formed(iqts_pkg::REQ_POLL, 7'd5, 16'd1, 8'h01);
    r.version = ~cur_ev;
    send_beat(r);                                                   // poll, no reply
    send_beat(well_formed(iqts_pkg::REQ_UNKNOWN, 7'd5, 16'd1, 8'h01));
    send_beat(well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h00));     // zero mask
    r = well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h01);
    r.confirmation = ~cur_cv;
    send_beat(r);                                                   // wrong confirmation
    r = well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h01);
    r.query_busy = 1'b1;
    send_beat(r);                                                   // lower engine busy
    r = well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h01);
    r.command_busy = 1'b1;
    send_beat(r);                                                   // not safe
    r = well_formed(iqts_pkg::REQ_START, 7'd5, 16'd1, 8'h01);
    r.start_ok = 1'b0;
    send_beat(r);                                                   // not safe
    send_beat(well_formed(iqts_pkg::REQ_START, 7'h7F, 16'hFFFF, 8'hFF)); // issued
    send_beat(well_formed(iqts_pkg::REQ_START, 7'h7F, 16'hFFFF, 8'hFF)); // in progress
    send_beat(well_formed(iqts_pkg::REQ_START, 7'h7F, 16'hFFFF, 8'h7F)); // mask differs
    send_beat(well_formed(iqts_pkg::REQ_START, 7'd3, 16'd9, 8'h01));     // slot taken
    send_beat(well_formed(iqts_pkg::REQ_GET, 7'h7F, 16'hFFFF, 8'h00));   // in progress
    r = well_formed(iqts_pkg::REQ_POLL, 7'd0, 16'd0, 8'h00);
    r.query_busy = 1'b1;
    send_beat(r);                                                   // still running
    r = well_formed(iqts_pkg::REQ_POLL, 7'd0, 16'd0, 8'h00);
    r.result_present = 1'b1;
    r.result_masks   = '1;
    send_beat(r);                                                   // retire with result
    send_beat(well_formed(iqts_pkg::REQ_GET, 7'h7F, 16'hFFFF, 8'h00));   // complete
    send_beat(well_formed(iqts_pkg::REQ_START, 7'h7F, 16'hFFFF, 8'h01)); // done, mask differs
    send_beat(well_formed(iqts_pkg::REQ_START, 7'h7F, 16'hFFFF, 8'hFF)); // done, cached
    send_beat(well_formed(iqts_pkg::REQ_START, 7'd0, 16'd0, 8'h01));     // issued
    r = well_formed(iqts_pkg::REQ_POLL, 7'd0, 16'd0, 8'h00);
    r.result_masks = '1;
    send_beat(r);                                                   // retire, no result
    send_beat(well_formed(iqts_pkg::REQ_GET, 7'd0, 16'd0, 8'h00));       // no cached result
    send_beat(well_formed(iqts_pkg::REQ_START, 7'd1, 16'h8000, 8'h80));  // issued
    r = well_formed(iqts_pkg::REQ_POLL, 7'd0, 16'd0, 8'h00);
    r.result_present = 1'b1;
    r.maint_code     = 8'hFF;
    send_beat(r);                                                   // retire, maint error
    send_beat(well_formed(iqts_pkg::REQ_GET, 7'd1, 16'h8000, 8'h00));    // internal error
    settle();

    // Opposite extremes, opening with a gapless stretch
    program_regs(8'hFF, 8'h00, 16'hFFFF, 1'b0);
    run_random(450, 450, 150);
    settle();

    // Random settings, with a long response stall
    program_regs(8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    run_random(450, 60, 0);
    settle();

    program_regs(8'h80, 8'h7F, 16'h8000, 1'b0);
    run_random(425, 200, 0);
    settle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
